// File: rtl/stlf_pkg.sv
// ----------------------------------------------------------------------------
// stlf_pkg
// Shared types, constants and the sine table builder for the tone generator.
// ----------------------------------------------------------------------------
package stlf_pkg;

  localparam int unsigned SINE_DEPTH = 1024;
  localparam int unsigned SINE_AW    = $clog2(SINE_DEPTH);
  localparam logic [14:0] PEAK_LEVEL = 15'd30000;
  localparam logic [23:0] SHORT_TONE = 24'd8820;
  localparam logic [31:0] RECIP10    = 32'hCCCCCCCD;
  localparam logic [16:0] FULL_LEVEL = 17'h10000;
  localparam logic [23:0] TONE_LENGTH_RST = 24'd44100;

  // register indexes
  localparam logic REG_PHASE_STEP  = 1'b0;
  localparam logic REG_TONE_LENGTH = 1'b1;

  // jump conditions of the control program
  localparam logic [2:0] COND_NEVER     = 3'd0;
  localparam logic [2:0] COND_ALWAYS    = 3'd1;
  localparam logic [2:0] COND_NO_ACCEPT = 3'd2;
  localparam logic [2:0] COND_INACTIVE  = 3'd3;
  localparam logic [2:0] COND_MIDDLE    = 3'd4;
  localparam logic [2:0] COND_DIV_BUSY  = 3'd5;
  localparam logic [2:0] COND_OUT_FULL  = 3'd6;

  typedef struct packed {
    logic       in_ready;
    logic       start;
    logic       check;
    logic       classify;
    logic       env_write;
    logic       mul1;
    logic       mul2;
    logic       emit;
    logic [2:0] cond;
    logic [3:0] target;
  } ucode_t;

  typedef struct packed {
    logic inactive;
    logic middle;
    logic div_busy;
    logic out_full;
  } stat_t;

  typedef logic [15:0] sine_rom_t [SINE_DEPTH];

  localparam longint unsigned HALF_PI_Q30 = 64'd1686629713;
  localparam longint unsigned TAYLOR_DIV [1:8] = '{64'd6, 64'd20, 64'd42, 64'd72,
                                                   64'd110, 64'd156, 64'd210, 64'd272};

  // sin(num / SINE_DEPTH * pi/2) scaled to 32767
  function automatic int quarter_sine(longint unsigned num);
    longint unsigned x;
    longint unsigned x2;
    longint unsigned term;
    longint          sum;
    x    = (num * HALF_PI_Q30) / SINE_DEPTH;
    x2   = (x * x) >> 30;
    term = x;
    sum  = 0;
    for (int k = 1; k <= 8; k++) begin
      if ((k % 2) == 1) begin
        sum = sum + longint'(term);
      end else begin
        sum = sum - longint'(term);
      end
      term = ((term * x2) >> 30) / TAYLOR_DIV[k];
    end
    if (sum < 0) begin
      sum = 0;
    end
    sum = (sum * 32767 + (longint'(1) << 29)) >>> 30;
    if (sum > 32767) begin
      sum = 32767;
    end
    return int'(sum);
  endfunction

  function automatic sine_rom_t build_sine_rom();
    sine_rom_t       rom;
    longint unsigned a;
    longint unsigned d;
    int              v;
    d = SINE_DEPTH;
    for (int n = 0; n < SINE_DEPTH; n++) begin
      a = 4 * longint'(n);
      if (a < d) begin
        v = quarter_sine(a);
      end else if (a < 2 * d) begin
        v = quarter_sine(2 * d - a);
      end else if (a < 3 * d) begin
        v = -quarter_sine(a - 2 * d);
      end else begin
        v = -quarter_sine(4 * d - a);
      end
      rom[n] = 16'(v);
    end
    return rom;
  endfunction

endpackage

// File: rtl/sine_tone_with_linear_fades.sv
// ----------------------------------------------------------------------------
// sine_tone_with_linear_fades
// Sine tone generator with linear attack and release, one sample per input.
// ----------------------------------------------------------------------------
// Each input transaction yields one output sample. A sample in the attack or
// release has its next envelope level computed by the 17-step restoring
// divider. The input is taken again while a finished sample waits in the
// output register. The ramp length is latched on restart as 40% of
// tone_length below 8820 samples, else 10%.
module sine_tone_with_linear_fades (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_we,
  input  logic        cfg_index,
  input  logic [31:0] cfg_data,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [7:0]  s_tdata,   // [0] restart, [7:1] zero
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [15:0] m_tdata,   // [15:0] sample_value
  output logic        m_tlast,
  output logic        m_tuser    // [0] tone_active
);

  stlf_pkg::ucode_t ctrl;
  stlf_pkg::stat_t  stat;
  logic [23:0]      div_num;
  logic [23:0]      div_den;
  logic [16:0]      div_quot;
  logic             div_busy;

  assign s_tready = ctrl.in_ready;

  stlf_seq u_seq (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .stat     (stat),
    .ctrl     (ctrl)
  );

  stlf_div u_div (
    .clk  (clk),
    .rst  (rst),
    .load (ctrl.classify),
    .num  (div_num),
    .den  (div_den),
    .quot (div_quot),
    .busy (div_busy)
  );

  stlf_dp u_dp (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .s_tvalid  (s_tvalid),
    .s_tdata   (s_tdata),
    .ctrl      (ctrl),
    .div_busy  (div_busy),
    .div_quot  (div_quot),
    .stat      (stat),
    .div_num   (div_num),
    .div_den   (div_den),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .m_tlast   (m_tlast),
    .m_tuser   (m_tuser)
  );

`ifndef SYNTH
  a_last_in_tone: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && m_tlast) |-> m_tuser)
    else $error("last sample outside a tone");

  a_idle_is_zero: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && !m_tuser) |-> (m_tdata == 16'd0 && !m_tlast))
    else $error("nonzero sample outside a tone");

  a_one_at_a_time: assert property (@(posedge clk) disable iff (rst)
    (s_tvalid && s_tready) |=> !s_tready)
    else $error("input taken while a sample is in progress");

  a_div_done_before_env: assert property (@(posedge clk) disable iff (rst)
    ctrl.env_write |-> !div_busy)
    else $error("envelope written while divider busy");
`endif

endmodule

// File: rtl/stlf_div.sv
// ----------------------------------------------------------------------------
// stlf_div
// Restoring divider for fade levels: quot = floor(num * 65536 / den), num <= den.
// ----------------------------------------------------------------------------
module stlf_div (
  input  logic        clk,
  input  logic        rst,
  input  logic        load,
  input  logic [23:0] num,
  input  logic [23:0] den,
  output logic [16:0] quot,
  output logic        busy
);

  logic [24:0] rem;
  logic [23:0] den_q;
  logic [16:0] q;
  logic [4:0]  cnt;
  logic        ge;
  logic [24:0] rem_sub;

  assign ge      = rem >= {1'b0, den_q};
  assign rem_sub = ge ? rem - {1'b0, den_q} : rem;
  assign busy    = cnt != 5'd0;
  assign quot    = q;

  always_ff @(posedge clk) begin
    if (rst) begin
      cnt <= 5'd0;
    end else if (load) begin
      cnt <= 5'd17;
    end else if (busy) begin
      cnt <= cnt - 5'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      rem   <= {1'b0, num};
      den_q <= den;
      q     <= 17'd0;
    end else if (busy) begin
      q   <= {q[15:0], ge};
      rem <= {rem_sub[23:0], 1'b0};
    end
  end

endmodule

// File: rtl/stlf_seq.sv
// ----------------------------------------------------------------------------
// stlf_seq
// Step counter and control program for one sample.
// ----------------------------------------------------------------------------
module stlf_seq (
  input  logic             clk,
  input  logic             rst,
  input  logic             s_tvalid,
  input  stlf_pkg::stat_t  stat,
  output stlf_pkg::ucode_t ctrl
);

  localparam logic [3:0] S_WAIT  = 4'd0;
  localparam logic [3:0] S_START = 4'd1;
  localparam logic [3:0] S_CHECK = 4'd2;
  localparam logic [3:0] S_CLASS = 4'd3;
  localparam logic [3:0] S_DIV   = 4'd4;
  localparam logic [3:0] S_ENV   = 4'd5;
  localparam logic [3:0] S_MUL1  = 4'd6;
  localparam logic [3:0] S_MUL2  = 4'd7;
  localparam logic [3:0] S_WOUT  = 4'd8;
  localparam logic [3:0] S_EMIT  = 4'd9;

  logic [3:0] step;
  logic [3:0] step_next;
  logic       jump;

  function automatic stlf_pkg::ucode_t program_word(logic [3:0] s);
    stlf_pkg::ucode_t w;
    w = '0;
    unique case (s)
      S_WAIT: begin
        w.in_ready = 1'b1;
        w.cond     = stlf_pkg::COND_NO_ACCEPT;
        w.target   = S_WAIT;
      end
      S_START: w.start = 1'b1;
      S_CHECK: begin
        w.check  = 1'b1;
        w.cond   = stlf_pkg::COND_INACTIVE;
        w.target = S_WOUT;
      end
      S_CLASS: begin
        w.classify = 1'b1;
        w.cond     = stlf_pkg::COND_MIDDLE;
        w.target   = S_MUL1;
      end
      S_DIV: begin
        w.cond   = stlf_pkg::COND_DIV_BUSY;
        w.target = S_DIV;
      end
      S_ENV:  w.env_write = 1'b1;
      S_MUL1: w.mul1 = 1'b1;
      S_MUL2: w.mul2 = 1'b1;
      S_WOUT: begin
        w.cond   = stlf_pkg::COND_OUT_FULL;
        w.target = S_WOUT;
      end
      S_EMIT: begin
        w.emit   = 1'b1;
        w.cond   = stlf_pkg::COND_ALWAYS;
        w.target = S_WAIT;
      end
      default: begin
        w.cond   = stlf_pkg::COND_ALWAYS;
        w.target = S_WAIT;
      end
    endcase
    return w;
  endfunction

  assign ctrl = program_word(step);

  always_comb begin
    unique case (ctrl.cond)
      stlf_pkg::COND_NEVER:     jump = 1'b0;
      stlf_pkg::COND_ALWAYS:    jump = 1'b1;
      stlf_pkg::COND_NO_ACCEPT: jump = !s_tvalid;
      stlf_pkg::COND_INACTIVE:  jump = stat.inactive;
      stlf_pkg::COND_MIDDLE:    jump = stat.middle;
      stlf_pkg::COND_DIV_BUSY:  jump = stat.div_busy;
      stlf_pkg::COND_OUT_FULL:  jump = stat.out_full;
      default:                  jump = 1'b0;
    endcase
    step_next = jump ? ctrl.target : step + 4'd1;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      step <= S_WAIT;
    end else begin
      step <= step_next;
    end
  end

endmodule

// File: rtl/stlf_dp.sv
// ----------------------------------------------------------------------------
// stlf_dp
// Datapath: config registers, phase and envelope state, sine table, scaling
// multipliers and the output register.
// ----------------------------------------------------------------------------
module stlf_dp (
  input  logic             clk,
  input  logic             rst,
  input  logic             cfg_we,
  input  logic             cfg_index,
  input  logic [31:0]      cfg_data,
  input  logic             s_tvalid,
  input  logic [7:0]       s_tdata,
  input  stlf_pkg::ucode_t ctrl,
  input  logic             div_busy,
  input  logic [16:0]      div_quot,
  output stlf_pkg::stat_t  stat,
  output logic [23:0]      div_num,
  output logic [23:0]      div_den,
  output logic             m_tvalid,
  input  logic             m_tready,
  output logic [15:0]      m_tdata,
  output logic             m_tlast,
  output logic             m_tuser
);

  localparam stlf_pkg::sine_rom_t SINE_ROM = stlf_pkg::build_sine_rom();

  logic [31:0] phase_step;
  logic [23:0] tone_length;
  logic [31:0] phase;
  logic [23:0] sample_index;
  logic [23:0] ramp_length;
  logic [16:0] envelope_level;
  logic        running;
  logic        restart_q;
  logic        inactive_q;
  logic [16:0] env_cur;
  logic [15:0] rom_q;
  logic [30:0] prod1;
  logic        sneg;
  logic [15:0] val_q;

  logic        inactive;
  logic        attack;
  logic        middle;
  logic [24:0] sum_kr;
  logic [25:0] ramp_x;
  logic [57:0] ramp_prod;
  logic [23:0] ramp_next;
  logic [15:0] abs_s;
  logic [47:0] prod2;
  logic [16:0] mag;
  logic [16:0] mag_signed;
  logic [24:0] k_inc;

  assign inactive  = !running || (sample_index >= tone_length);
  assign attack    = sample_index < ramp_length;
  assign sum_kr    = {1'b0, sample_index} + {1'b0, ramp_length};
  assign middle    = !attack && (sum_kr < {1'b0, tone_length});
  assign ramp_x    = (tone_length < stlf_pkg::SHORT_TONE) ? {tone_length, 2'b00}
                                                          : {2'b00, tone_length};
  assign ramp_prod = 58'(ramp_x) * 58'(stlf_pkg::RECIP10);
  assign ramp_next = 24'(ramp_prod[57:35]);
  assign div_num   = attack ? sample_index : tone_length - sample_index;
  assign div_den   = ramp_length;
  assign abs_s     = rom_q[15] ? 16'(-rom_q) : rom_q;
  assign prod2     = 48'(prod1) * 48'(env_cur);
  assign mag       = prod2[47:31];
  assign mag_signed = sneg ? 17'(-mag) : mag;
  assign k_inc     = {1'b0, sample_index} + 25'd1;

  assign stat.inactive = inactive;
  assign stat.middle   = middle;
  assign stat.div_busy = div_busy;
  assign stat.out_full = m_tvalid && !m_tready;

  always_ff @(posedge clk) begin
    if (rst) begin
      phase_step  <= 32'd0;
      tone_length <= stlf_pkg::TONE_LENGTH_RST;
    end else if (cfg_we) begin
      case (cfg_index)
        stlf_pkg::REG_PHASE_STEP:  phase_step  <= cfg_data;
        stlf_pkg::REG_TONE_LENGTH: tone_length <= cfg_data[23:0];
        default: ;
      endcase
    end
  end

  // tone state
  always_ff @(posedge clk) begin
    if (rst) begin
      phase          <= 32'd0;
      sample_index   <= 24'd0;
      ramp_length    <= 24'd0;
      envelope_level <= 17'd0;
      running        <= 1'b0;
    end else if (ctrl.start) begin
      if (restart_q) begin
        phase          <= 32'd0;
        sample_index   <= 24'd0;
        ramp_length    <= ramp_next;
        envelope_level <= 17'd0;
        running        <= tone_length != 24'd0;
      end
    end else if (ctrl.env_write) begin
      envelope_level <= div_quot;
    end else if (ctrl.emit) begin
      if (inactive_q) begin
        running <= 1'b0;
      end else begin
        phase        <= phase + phase_step;
        sample_index <= k_inc[23:0];
        if (k_inc >= {1'b0, tone_length}) begin
          running <= 1'b0;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (s_tvalid && ctrl.in_ready) begin
      restart_q <= s_tdata[0];
    end
    if (ctrl.check) begin
      inactive_q <= inactive;
      rom_q      <= SINE_ROM[phase[31 -: stlf_pkg::SINE_AW]];
    end
    if (ctrl.classify) begin
      env_cur <= middle ? stlf_pkg::FULL_LEVEL : envelope_level;
    end
    if (ctrl.mul1) begin
      prod1 <= 31'(stlf_pkg::PEAK_LEVEL) * 31'(abs_s);
      sneg  <= rom_q[15];
    end
    if (ctrl.mul2) begin
      val_q <= mag_signed[15:0];
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (ctrl.emit) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl.emit) begin
      m_tdata <= inactive_q ? 16'd0 : val_q;
      m_tlast <= !inactive_q && (k_inc == {1'b0, tone_length});
      m_tuser <= !inactive_q;
    end
  end

endmodule

// File: test/tb_top.sv
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the sine tone generator with linear fades.
// Restart/step transactions go in through the input stream. Each accepted
// transaction advances a bit-exact tone predictor (phase accumulator, sine
// table, attack/full/release envelope). Output samples are compared field by
// field against the oldest prediction. Both stream sides idle at random.
// ----------------------------------------------------------------------------
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  typedef longint unsigned u64_t;

  typedef struct packed {
    logic signed [15:0] value;
    logic               last;
    logic               active;
  } tone_sample_t;

  localparam int unsigned CYCLE_LIMIT  = 400000;
  localparam int unsigned RANDOM_ITEMS = 850;
  localparam int unsigned SHOWN_ERRORS = 100;
  localparam u64_t        HALF_PI_Q30V = 64'd1686629713;
  localparam u64_t        PEAK_GAIN    = 64'd30000;
  localparam u64_t        TABLE_DEPTH  = 64'd1024;

  logic        clk       = 1'b0;
  logic        rst       = 1'b1;
  logic        cfg_we    = 1'b0;
  logic        cfg_index = 1'b0;
  logic [31:0] cfg_data  = '0;
  logic        s_tvalid  = 1'b0;
  logic        s_tready;
  logic [7:0]  s_tdata   = '0;  // [0] restart, [7:1] zero
  logic        m_tvalid;
  logic        m_tready  = 1'b0;
  logic [15:0] m_tdata;         // [15:0] sample_value
  logic        m_tlast;
  logic        m_tuser;         // [0] tone_active

  // tone predictor state
  logic [31:0]        step_cfg;
  logic [23:0]        length_cfg;
  logic [31:0]        acc_phase;
  logic [23:0]        pos;
  logic [23:0]        ramp;
  logic [16:0]        fade_lvl;
  logic               playing;
  logic signed [15:0] sine_table [TABLE_DEPTH];

  bit           pending_restarts [$];
  tone_sample_t expected_samples [$];
  int unsigned  items_queued = 0;
  int unsigned  items_taken  = 0;
  int unsigned  errors       = 0;
  int unsigned  cycles       = 0;
  bit           jitter       = 1'b1;

  sine_tone_with_linear_fades u_top (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .m_tlast   (m_tlast),
    .m_tuser   (m_tuser)
  );

  always #6 clk = ~clk;

  function automatic int quarter_wave(u64_t num);
    u64_t   x;
    u64_t   x2;
    u64_t   term;
    longint acc;
    x    = (num * HALF_PI_Q30V) / TABLE_DEPTH;
    x2   = (x * x) >> 30;
    term = x;
    acc  = 0;
    for (int k = 1; k <= 8; k++) begin
      if ((k % 2) == 1) begin
        acc = acc + longint'(term);
      end else begin
        acc = acc - longint'(term);
      end
      term = ((term * x2) >> 30) / u64_t'((2 * k) * (2 * k + 1));
    end
    if (acc < 0) begin
      acc = 0;
    end
    acc = (acc * 32767 + (longint'(1) << 29)) >>> 30;
    if (acc > 32767) begin
      acc = 32767;
    end
    return int'(acc);
  endfunction

  function automatic logic [16:0] fade_step(logic [23:0] num, logic [23:0] r);
    u64_t q;
    if (r == 0) begin
      return stlf_pkg::FULL_LEVEL;
    end
    q = (u64_t'(num) << 16) / u64_t'(r);
    return (q > 64'd65536) ? stlf_pkg::FULL_LEVEL : q[16:0];
  endfunction

  function automatic tone_sample_t advance_tone(bit restart);
    tone_sample_t res;
    logic [24:0]  k1;
    logic [15:0]  entry;
    logic [15:0]  magn;
    logic [16:0]  env;
    u64_t         mag;
    logic [15:0]  val;
    res = '0;
    if (restart) begin
      acc_phase = '0;
      pos       = '0;
      fade_lvl  = '0;
      ramp      = (length_cfg < stlf_pkg::SHORT_TONE)
                  ? 24'((u64_t'(length_cfg) * 4) / 10)
                  : 24'(u64_t'(length_cfg) / 10);
      playing   = (length_cfg != 0);
    end
    if (!playing) begin
      return res;
    end
    if (pos >= length_cfg) begin
      playing = 1'b0;
      return res;
    end
    if (pos < ramp) begin
      env      = fade_lvl;
      fade_lvl = fade_step(pos, ramp);
    end else if ({1'b0, pos} + {1'b0, ramp} >= {1'b0, length_cfg}) begin
      env      = fade_lvl;
      fade_lvl = fade_step(length_cfg - pos, ramp);
    end else begin
      env = stlf_pkg::FULL_LEVEL;
    end
    entry = sine_table[acc_phase[31:22]];
    magn  = entry[15] ? -entry : entry;
    mag   = (PEAK_GAIN * u64_t'(magn) * u64_t'(env)) >> 31;
    val   = entry[15] ? -mag[15:0] : mag[15:0];
    k1    = {1'b0, pos} + 25'd1;
    res.value  = val;
    res.last   = (k1 == {1'b0, length_cfg});
    res.active = 1'b1;
    acc_phase  = acc_phase + step_cfg;
    pos        = k1[23:0];
    if (k1 >= {1'b0, length_cfg}) begin
      playing = 1'b0;
    end
    return res;
  endfunction

  task automatic flag_mismatch(string msg);
    errors++;
    if (errors <= SHOWN_ERRORS) begin
      $display("tb_top: mismatch at cycle %0d: %s", cycles, msg);
    end
  endtask

  task automatic push_item(bit restart);
    pending_restarts.push_back(restart);
    items_queued++;
  endtask

  task automatic write_reg(logic idx, logic [31:0] val);
    @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(posedge clk);
    cfg_we <= 1'b0;
    if (idx == stlf_pkg::REG_PHASE_STEP) begin
      step_cfg = val;
    end else begin
      length_cfg = val[23:0];
    end
  endtask

  task automatic wait_idle();
    while (items_taken != items_queued || expected_samples.size() != 0) begin
      @(posedge clk);
    end
  endtask

  // input driver
  always @(posedge clk) begin
    if (rst) begin
      s_tvalid <= 1'b0;
      s_tdata  <= '0;
    end else begin
      if (s_tvalid && s_tready) begin
        expected_samples.push_back(advance_tone(s_tdata[0]));
        items_taken++;
      end
      if (!s_tvalid || s_tready) begin
        if (pending_restarts.size() != 0 && !(jitter && $urandom_range(99) < 6)) begin
          s_tvalid <= 1'b1;
          s_tdata  <= {7'd0, pending_restarts.pop_front()};
        end else begin
          s_tvalid <= 1'b0;
        end
      end
    end
  end

  // output monitor
  always @(posedge clk) begin : sample_check
    tone_sample_t want;
    if (rst) begin
      m_tready <= 1'b0;
    end else begin
      if (m_tvalid && m_tready) begin
        if (expected_samples.size() == 0) begin
          flag_mismatch("sample transaction with nothing expected");
        end else begin
          want = expected_samples.pop_front();
          if (m_tdata !== want.value) begin
            flag_mismatch($sformatf("sample_value %0d, expected %0d",
                                    $signed(m_tdata), want.value));
          end
          if (m_tlast !== want.last) begin
            flag_mismatch($sformatf("last_sample %0b, expected %0b", m_tlast, want.last));
          end
          if (m_tuser !== want.active) begin
            flag_mismatch($sformatf("tone_active %0b, expected %0b", m_tuser, want.active));
          end
        end
      end
      m_tready <= !(jitter && $urandom_range(99) < 6);
    end
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("tb_top: errors");
      $finish;
    end
  end

  initial begin
    u64_t          a;
    int            v;
    logic [31:0]   new_step;
    logic [23:0]   new_len;
    int unsigned   pick;
    int unsigned   n;
    for (int i = 0; i < TABLE_DEPTH; i++) begin
      a = 4 * u64_t'(i);
      if (a < TABLE_DEPTH) begin
        v = quarter_wave(a);
      end else if (a < 2 * TABLE_DEPTH) begin
        v = quarter_wave(2 * TABLE_DEPTH - a);
      end else if (a < 3 * TABLE_DEPTH) begin
        v = -quarter_wave(a - 2 * TABLE_DEPTH);
      end else begin
        v = -quarter_wave(4 * TABLE_DEPTH - a);
      end
      sine_table[i] = 16'(v);
    end
    step_cfg   = '0;
    length_cfg = stlf_pkg::TONE_LENGTH_RST;
    acc_phase  = '0;
    pos        = '0;
    ramp       = '0;
    fade_lvl   = '0;
    playing    = 1'b0;

    repeat (9) @(posedge clk);
    rst <= 1'b0;

    // idle step, then a tone with the reset settings
    push_item(1'b0);
    push_item(1'b1);
    push_item(1'b0);
    push_item(1'b0);
    wait_idle();
    // one-sample tone, largest phase step
    write_reg(stlf_pkg::REG_PHASE_STEP, 32'hFFFF_FFFF);
    write_reg(stlf_pkg::REG_TONE_LENGTH, 32'd1);
    push_item(1'b1);
    push_item(1'b0);
    push_item(1'b1);
    wait_idle();
    // short tone through attack, release and past the end
    write_reg(stlf_pkg::REG_PHASE_STEP, 32'h1111_1111);
    write_reg(stlf_pkg::REG_TONE_LENGTH, 32'd8);
    push_item(1'b1);
    repeat (8) push_item(1'b0);
    wait_idle();
    // zero length starts nothing
    write_reg(stlf_pkg::REG_TONE_LENGTH, 32'd0);
    push_item(1'b1);
    push_item(1'b0);
    wait_idle();
    // length cut below the sample index while a tone runs
    write_reg(stlf_pkg::REG_PHASE_STEP, 32'h4000_0000);
    write_reg(stlf_pkg::REG_TONE_LENGTH, 32'd20);
    push_item(1'b1);
    repeat (5) push_item(1'b0);
    wait_idle();
    write_reg(stlf_pkg::REG_TONE_LENGTH, 32'd3);
    push_item(1'b0);
    wait_idle();
    // longest tone
    write_reg(stlf_pkg::REG_TONE_LENGTH, 32'h00FF_FFFF);
    push_item(1'b1);
    push_item(1'b0);
    wait_idle();

    while (items_queued < 25 + RANDOM_ITEMS) begin
      jitter = !(items_queued > 350 && items_queued < 500);
      case ($urandom_range(7))
        0:       new_step = '0;
        1:       new_step = 32'hFFFF_FFFF;
        2:       new_step = $urandom_range(1 << 20);
        default: new_step = $urandom;
      endcase
      pick = $urandom_range(99);
      if (pick < 65) begin
        new_len = 24'($urandom_range(1, 40));
      end else if (pick < 80) begin
        new_len = 24'($urandom_range(41, 400));
      end else if (pick < 88) begin
        new_len = 24'($urandom_range(8815, 8825));
      end else if (pick < 94) begin
        new_len = 24'($urandom_range(1, 24'hFF_FFFF));
      end else if (pick < 97) begin
        new_len = 24'hFF_FFFF;
      end else begin
        new_len = '0;
      end
      if ($urandom_range(4) != 0) begin
        write_reg(stlf_pkg::REG_PHASE_STEP, new_step);
      end
      if ($urandom_range(4) != 0) begin
        write_reg(stlf_pkg::REG_TONE_LENGTH, {8'd0, new_len});
      end
      n = (length_cfg <= 40) ? length_cfg + $urandom_range(1, 3) : $urandom_range(8, 40);
      if ($urandom_range(9) != 0) begin
        push_item(1'b1);
      end
      repeat (n) push_item($urandom_range(99) < 3);
      wait_idle();
    end

    jitter = 1'b1;
    wait_idle();
    repeat (40) @(posedge clk);
    if (errors == 0) begin
      $display("tb_top: clean");
    end else begin
      $display("tb_top: errors");
    end
    $finish;
  end

endmodule
